### rtl/gpde_pkg.sv
// shared types, constants and helpers for the gamepad report to delta event block
package gpde_pkg;

  // report decoding
  localparam logic [7:0] MIN_STATE_LEN  = 8'd18;
  localparam logic [7:0] MIN_STATUS_LEN = 8'd2;
  localparam logic [7:0] STATUS_CONNECT = 8'd2;
  localparam int         TRIG_SHIFT     = 7;

  // d-pad bit positions in the button mask
  localparam int BIT_DPAD_DOWN  = 10;
  localparam int BIT_DPAD_RIGHT = 11;
  localparam int BIT_DPAD_LEFT  = 12;
  localparam int BIT_DPAD_UP    = 13;

  localparam int NUM_KEYS   = 16;
  localparam int NUM_AXES   = 6;
  localparam int NUM_HATS   = 2;
  localparam int NUM_SLOTS  = NUM_AXES + NUM_HATS;
  localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int VALUE_W    = 16;

  // report kinds
  localparam logic FUNC_STATE  = 1'b0;
  localparam logic FUNC_STATUS = 1'b1;

  // event kinds
  localparam logic [1:0] EV_KEY  = 2'd0;
  localparam logic [1:0] EV_AXIS = 2'd1;
  localparam logic [1:0] EV_SYNC = 2'd2;

  // axis slot indexes
  localparam logic [SLOT_IDX_W-1:0] AX_X    = 3'd0;
  localparam logic [SLOT_IDX_W-1:0] AX_Y    = 3'd1;
  localparam logic [SLOT_IDX_W-1:0] AX_RX   = 3'd2;
  localparam logic [SLOT_IDX_W-1:0] AX_RY   = 3'd3;
  localparam logic [SLOT_IDX_W-1:0] AX_Z    = 3'd4;
  localparam logic [SLOT_IDX_W-1:0] AX_RZ   = 3'd5;
  localparam logic [SLOT_IDX_W-1:0] AX_HATX = 3'd6;
  localparam logic [SLOT_IDX_W-1:0] AX_HATY = 3'd7;

  typedef struct packed {
    logic               func;
    logic [7:0]         report_len;
    logic [7:0]         status_code;
    logic [31:0]        buttons;
    logic signed [15:0] trigger_left;
    logic signed [15:0] trigger_right;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [3:0]         event_code;
    logic signed [15:0] event_value;
    logic               last_event;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS,
    ST_AXES,
    ST_SYNC
  } state_t;

  // button mask bit for each key in map order
  function automatic logic [4:0] key_bit_pos(input logic [KEY_IDX_W-1:0] idx);
    logic [4:0] pos;
    unique case (idx)
      4'd0:    pos = 5'd0;
      4'd1:    pos = 5'd1;
      4'd2:    pos = 5'd2;
      4'd3:    pos = 5'd3;
      4'd4:    pos = 5'd19;
      4'd5:    pos = 5'd9;
      4'd6:    pos = 5'd14;
      4'd7:    pos = 5'd6;
      4'd8:    pos = 5'd16;
      4'd9:    pos = 5'd15;
      4'd10:   pos = 5'd5;
      4'd11:   pos = 5'd7;
      4'd12:   pos = 5'd17;
      4'd13:   pos = 5'd8;
      4'd14:   pos = 5'd18;
      default: pos = 5'd4;
    endcase
    return pos;
  endfunction

  // stick y: up positive becomes down positive, most negative clamps
  function automatic logic signed [15:0] negate_clamped(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

  // triggers: negative reads as released, rest scaled to 0..255
  function automatic logic signed [15:0] trigger_scale(input logic signed [15:0] v);
    return v[15] ? 16'sd0 : {{TRIG_SHIFT{1'b0}}, v[15:TRIG_SHIFT]};
  endfunction

  // hat from two opposing bits, positive wins
  function automatic logic signed [15:0] hat_value(input logic pos_bit, input logic neg_bit);
    return pos_bit ? 16'sd1 : (neg_bit ? -16'sd1 : 16'sd0);
  endfunction

endpackage

### rtl/gpde_ram.sv
// generic single-port-write, single-port-read ram with registered read
module gpde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/gamepad_report_to_delta_events.sv
// top level: controller reports in, change-only key, axis and sync events out
//
//   channel   handshake            payload     dir
//   -------   ------------------   ---------   ---
//   in        in_valid/in_ready    in_item     in   one parsed report per item
//   out       out_valid/out_ready  out_item    out  one input event per item
//
// a state report is accepted, then scanned: the key scan (one key per cycle
// while the output is not held), the axis and hat slots (one ram entry per
// cycle likewise, the read of the next slot overlapping the compare of the
// current one) and the sync marker. status reports and short reports stay idle.
// rst clears the connected flag, the stored buttons and the slot valid bits;
// an invalid slot reads as zero, so the ram needs no clearing pass.
// a held output stalls the scan only on a cycle that has an event to emit.
module gamepad_report_to_delta_events
  import gpde_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // sequencer state
  state_t                  state, state_next;
  logic [KEY_IDX_W-1:0]    key_idx, key_idx_next;
  logic [SLOT_IDX_W-1:0]   slot_idx, slot_idx_next;
  logic                    emitted, emitted_next;

  // pad state kept in flops
  logic                    connected, connected_next;
  logic [31:0]             prev_buttons, prev_buttons_next;
  logic [NUM_SLOTS-1:0]    slot_valid, slot_valid_next;

  // current report, held for the whole scan
  in_item_t                cur;

  // ram port signals
  logic                    ram_wr_en;
  logic                    ram_rd_en;
  logic [SLOT_IDX_W-1:0]   ram_rd_addr;
  logic [VALUE_W-1:0]      ram_rd_data;

  // event builder
  logic                    out_free;
  logic                    emit;
  out_item_t               emit_item;
  logic                    in_accept;

  logic [31:0]             btn_diff;
  logic [4:0]              key_pos;
  logic                    key_changed;
  logic signed [15:0]      slot_new;
  logic signed [15:0]      slot_old;
  logic                    slot_changed;
  logic                    do_connect;
  logic                    conn_on;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // state slots live in the ram, one per axis and hat
  gpde_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot_idx),
    .wr_data (slot_new),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // key under test
  assign btn_diff    = cur.buttons ^ prev_buttons;
  assign key_pos     = key_bit_pos(key_idx);
  assign key_changed = btn_diff[key_pos];

  // fresh value of the slot under test
  always_comb begin
    unique case (slot_idx)
      AX_X:    slot_new = cur.left_x;
      AX_Y:    slot_new = negate_clamped(cur.left_y);
      AX_RX:   slot_new = cur.right_x;
      AX_RY:   slot_new = negate_clamped(cur.right_y);
      AX_Z:    slot_new = trigger_scale(cur.trigger_left);
      AX_RZ:   slot_new = trigger_scale(cur.trigger_right);
      AX_HATX: slot_new = hat_value(cur.buttons[BIT_DPAD_RIGHT], cur.buttons[BIT_DPAD_LEFT]);
      default: slot_new = hat_value(cur.buttons[BIT_DPAD_DOWN], cur.buttons[BIT_DPAD_UP]);
    endcase
  end

  // a slot not written since the last connect reads as zero
  assign slot_old     = slot_valid[slot_idx] ? ram_rd_data : '0;
  assign slot_changed = (slot_new != slot_old);

  // connect handling at accept time
  always_comb begin
    do_connect = 1'b0;
    conn_on    = 1'b0;
    if (in_accept) begin
      if (in_item.func == FUNC_STATUS) begin
        do_connect = (in_item.report_len >= MIN_STATUS_LEN);
        conn_on    = (in_item.status_code == STATUS_CONNECT);
      end else begin
        do_connect = (in_item.report_len >= MIN_STATE_LEN);
        conn_on    = 1'b1;
      end
    end
  end

  always_comb begin
    state_next        = state;
    key_idx_next      = key_idx;
    slot_idx_next     = slot_idx;
    emitted_next      = emitted;
    connected_next    = connected;
    prev_buttons_next = prev_buttons;
    slot_valid_next   = slot_valid;
    ram_wr_en         = 1'b0;
    ram_rd_en         = 1'b0;
    ram_rd_addr       = slot_idx + 1'b1;
    emit              = 1'b0;
    emit_item         = '0;

    unique case (state)
      ST_IDLE: begin
        // prime the read of the first slot
        ram_rd_en   = 1'b1;
        ram_rd_addr = '0;
        if (do_connect) begin
          if (conn_on && !connected) begin
            // fresh connection starts from a blank pad
            connected_next    = 1'b1;
            prev_buttons_next = '0;
            slot_valid_next   = '0;
          end else if (!conn_on) begin
            connected_next = 1'b0;
          end
          if (in_item.func == FUNC_STATE) begin
            state_next    = ST_KEYS;
            key_idx_next  = '0;
            slot_idx_next = '0;
            emitted_next  = 1'b0;
          end
        end
      end

      ST_KEYS: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = '0;
        if (!key_changed || out_free) begin
          if (key_changed) begin
            emit                  = 1'b1;
            emit_item.event_kind  = EV_KEY;
            emit_item.event_code  = key_idx;
            emit_item.event_value = {15'd0, cur.buttons[key_pos]};
            emitted_next          = 1'b1;
          end
          key_idx_next = key_idx + 1'b1;
          if (key_idx == KEY_IDX_W'(NUM_KEYS - 1)) begin
            state_next = ST_AXES;
          end
        end
      end

      ST_AXES: begin
        // read of the next slot only when this one retires, so rd_data holds
        if (!slot_changed || out_free) begin
          ram_rd_en = 1'b1;
          if (slot_changed) begin
            emit                        = 1'b1;
            emit_item.event_kind        = EV_AXIS;
            emit_item.event_code        = {1'b0, slot_idx};
            emit_item.event_value       = slot_new;
            emitted_next                = 1'b1;
            ram_wr_en                   = 1'b1;
            slot_valid_next[slot_idx]   = 1'b1;
          end
          slot_idx_next = slot_idx + 1'b1;
          if (slot_idx == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
            state_next = ST_SYNC;
          end
        end
      end

      ST_SYNC: begin
        if (!emitted || out_free) begin
          if (emitted) begin
            emit                 = 1'b1;
            emit_item.event_kind = EV_SYNC;
            emit_item.last_event = 1'b1;
          end
          prev_buttons_next = cur.buttons;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_idx      <= '0;
      slot_idx     <= '0;
      emitted      <= 1'b0;
      connected    <= 1'b0;
      prev_buttons <= '0;
      slot_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      key_idx      <= key_idx_next;
      slot_idx     <= slot_idx_next;
      emitted      <= emitted_next;
      connected    <= connected_next;
      prev_buttons <= prev_buttons_next;
      slot_valid   <= slot_valid_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur <= in_item;
    end
    if (emit) begin
      out_item <= emit_item;
    end
  end

endmodule

### tb/sv/testbench.sv
// self-checking testbench for gamepad_report_to_delta_events: directed and random reports
`timescale 1ns / 1ps
module testbench;
  import gpde_pkg::*;

  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT    = 5000;
  // long receiver hold-off so that the block backs up into its input
  localparam int SQUEEZE_CYCLES = 600;
  // settle time after the last expected event, longer than one full report scan
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 350;

  // button mask bit of each key, key index 0 in the low five bits
  localparam logic [NUM_KEYS*5-1:0] KEY_POS = {
    5'd4, 5'd18, 5'd8, 5'd17, 5'd7, 5'd5, 5'd15, 5'd16,
    5'd6, 5'd14, 5'd9, 5'd19, 5'd3, 5'd2, 5'd1, 5'd0
  };

  // status bytes other than connect
  localparam logic [7:0] STATUS_DROP = 8'd0;
  localparam logic [7:0] STATUS_ODD  = 8'hff;

  // d-pad combinations and bits that map to no key
  localparam logic [31:0] PAD_RIGHT_DOWN = (32'd1 << BIT_DPAD_RIGHT) | (32'd1 << BIT_DPAD_DOWN);
  localparam logic [31:0] PAD_LEFT_UP    = (32'd1 << BIT_DPAD_LEFT) | (32'd1 << BIT_DPAD_UP);
  localparam logic [31:0] UNMAPPED_HI    = 32'hfff0_0000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // pending reports and the events they are expected to cause
  in_item_t  stim_q[$];
  out_item_t events_due[$];
  out_item_t head_event;

  // shadow of the block's state: link flag, last buttons, last axis and hat slots
  logic        pad_on       = 1'b0;
  logic [31:0] seen_buttons = '0;
  int          seen_slot [NUM_SLOTS];

  // handshake bookkeeping shared between the clocked processes
  logic in_took   = 1'b0;
  logic out_took  = 1'b0;
  int   got_count = 0;
  int   mismatches = 0;

  // sender and receiver pacing
  int in_gap    = 0;
  int out_gap   = 0;
  int squeeze   = 0;
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  gamepad_report_to_delta_events uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // event prediction
  // ---------------------------------------------------------------------------

  // stick y: up positive becomes down positive, the one value without a negation saturates
  function automatic int stick_down(input logic [15:0] raw);
    int t;
    t = int'($signed(raw));
    t = -t;
    return (t > 32767) ? 32767 : t;
  endfunction

  // trigger: anything below zero reads as released, the rest keeps its top bits
  function automatic int trigger_level(input logic [15:0] raw);
    int t;
    t = int'($signed(raw));
    return (t < 0) ? 0 : (t >> TRIG_SHIFT);
  endfunction

  // connecting from the disconnected state forgets everything seen before
  task automatic set_link(input logic on);
    if (pad_on != on) begin
      pad_on = on;
      if (on) begin
        seen_buttons = '0;
        for (int s = 0; s < NUM_SLOTS; s++) seen_slot[s] = 0;
      end
    end
  endtask

  // works out the events of one accepted report and queues them in order
  task automatic predict_events(input in_item_t r);
    int        slot_now [NUM_SLOTS];
    int        n;
    logic [4:0] pos;
    out_item_t ev;
    n = 0;
    if (r.func == FUNC_STATUS) begin
      // status item: link change only, never an event
      if (r.report_len >= MIN_STATUS_LEN) set_link(r.status_code == STATUS_CONNECT);
    end else if (r.report_len >= MIN_STATE_LEN) begin
      set_link(1'b1);
      ev.last_event = 1'b0;

      // keys in map order, only those whose bit moved
      for (int k = 0; k < NUM_KEYS; k++) begin
        pos = KEY_POS[k*5 +: 5];
        if (r.buttons[pos] != seen_buttons[pos]) begin
          ev.event_kind  = EV_KEY;
          ev.event_code  = 4'(k);
          ev.event_value = r.buttons[pos] ? 16'sd1 : 16'sd0;
          events_due.push_back(ev);
          n++;
        end
      end

      // sticks, triggers, then the two hats; right beats left, down beats up
      slot_now[AX_X]    = int'(r.left_x);
      slot_now[AX_Y]    = stick_down(r.left_y);
      slot_now[AX_RX]   = int'(r.right_x);
      slot_now[AX_RY]   = stick_down(r.right_y);
      slot_now[AX_Z]    = trigger_level(r.trigger_left);
      slot_now[AX_RZ]   = trigger_level(r.trigger_right);
      slot_now[AX_HATX] = r.buttons[BIT_DPAD_RIGHT] ? 1 : (r.buttons[BIT_DPAD_LEFT] ? -1 : 0);
      slot_now[AX_HATY] = r.buttons[BIT_DPAD_DOWN] ? 1 : (r.buttons[BIT_DPAD_UP] ? -1 : 0);

      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (slot_now[s] != seen_slot[s]) begin
          ev.event_kind  = EV_AXIS;
          ev.event_code  = 4'(s);
          ev.event_value = 16'(slot_now[s]);
          events_due.push_back(ev);
          seen_slot[s] = slot_now[s];
          n++;
        end
      end
      seen_buttons = r.buttons;

      // a sync marker closes the run, but only if there was one
      if (n > 0) begin
        ev.event_kind  = EV_SYNC;
        ev.event_code  = '0;
        ev.event_value = '0;
        ev.last_event  = 1'b1;
        events_due.push_back(ev);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // raw 16-bit sample, biased towards the extremes and the trigger step at 128
  function automatic logic [15:0] pick_raw16();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'($urandom_range(120, 136));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t state_rpt(input logic [7:0] len, input logic [31:0] btn,
                                         input logic [15:0] tl, input logic [15:0] tr,
                                         input logic [15:0] lx, input logic [15:0] ly,
                                         input logic [15:0] rx, input logic [15:0] ry);
    in_item_t r;
    r.func          = FUNC_STATE;
    r.report_len    = len;
    r.status_code   = 8'($urandom);
    r.buttons       = btn;
    r.trigger_left  = tl;
    r.trigger_right = tr;
    r.left_x        = lx;
    r.left_y        = ly;
    r.right_x       = rx;
    r.right_y       = ry;
    return r;
  endfunction

  // status item; the report fields it carries are noise
  function automatic in_item_t status_rpt(input logic [7:0] len, input logic [7:0] code);
    in_item_t r;
    r = state_rpt(len, $urandom, pick_raw16(), pick_raw16(), pick_raw16(), pick_raw16(),
                  pick_raw16(), pick_raw16());
    r.func        = FUNC_STATUS;
    r.status_code = code;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    in_item_t cur;
    in_item_t nxt;
    int       pick;
    for (int s = 0; s < NUM_SLOTS; s++) seen_slot[s] = 0;

    // short state report while disconnected: no events, stays disconnected
    stim_q.push_back(state_rpt(8'd17, 32'hffff_ffff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000));
    // status items too short to count
    stim_q.push_back(status_rpt(8'd1, STATUS_CONNECT));
    stim_q.push_back(status_rpt(8'd0, STATUS_CONNECT));
    // first full report connects, but nothing differs from the cleared state
    stim_q.push_back(state_rpt(8'd18, '0, '0, '0, '0, '0, '0, '0));
    // everything moves at once: all keys, both stick extremes, triggers full, both hats clash
    stim_q.push_back(state_rpt(8'd18, 32'hffff_ffff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000));
    // and all the way back, with negative triggers
    stim_q.push_back(state_rpt(8'd128, '0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                               16'h7fff, 16'h7fff));
    // hats left and up, triggers either side of the first step, small stick values
    stim_q.push_back(state_rpt(8'd18, PAD_LEFT_UP, 16'd127, 16'd128, 16'd1, 16'hffff,
                               16'hffff, 16'd1));
    // only unmapped bits change: no events, no sync
    stim_q.push_back(state_rpt(8'd18, PAD_LEFT_UP | UNMAPPED_HI, 16'd127, 16'd128, 16'd1,
                               16'hffff, 16'hffff, 16'd1));
    stim_q.push_back(state_rpt(8'd18, PAD_RIGHT_DOWN, 16'd255, 16'hffff, 16'd1, 16'hffff,
                               16'hffff, 16'd1));
    // connect while connected keeps the stored values
    stim_q.push_back(status_rpt(8'd2, STATUS_CONNECT));
    stim_q.push_back(state_rpt(8'd18, PAD_RIGHT_DOWN, 16'd255, 16'hffff, 16'd1, 16'hffff,
                               16'hffff, 16'd1));
    // disconnect, a short report that must not reconnect, then reconnect by report
    stim_q.push_back(status_rpt(8'd2, STATUS_DROP));
    stim_q.push_back(state_rpt(8'd0, PAD_RIGHT_DOWN, '0, '0, '0, '0, '0, '0));
    stim_q.push_back(state_rpt(8'd255, PAD_RIGHT_DOWN, 16'd255, 16'hffff, 16'd1, 16'hffff,
                               16'hffff, 16'd1));
    // disconnect and reconnect by status, then the same report emits again
    stim_q.push_back(status_rpt(8'd255, STATUS_ODD));
    stim_q.push_back(status_rpt(8'd2, STATUS_CONNECT));
    stim_q.push_back(state_rpt(8'd18, PAD_RIGHT_DOWN, 16'd255, 16'hffff, 16'd1, 16'hffff,
                               16'hffff, 16'd1));
    // reconnect by an all-zero report after a drop: cleared state, nothing to emit
    stim_q.push_back(status_rpt(8'd2, STATUS_DROP));
    stim_q.push_back(state_rpt(8'd18, '0, '0, '0, '0, '0, '0, '0));

    // random part: mostly a pad drifting from report to report, with noise mixed in
    cur = state_rpt(8'd18, '0, '0, '0, '0, '0, '0, '0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        nxt = cur;
        nxt.report_len  = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(18, 255)
                                                          : $urandom_range(18, 40));
        nxt.status_code = 8'($urandom);
        case ($urandom_range(0, 3))
          0:       nxt.buttons = nxt.buttons ^ (32'd1 << $urandom_range(0, 31));
          1:       nxt.buttons = nxt.buttons ^ ($urandom & $urandom);
          2:       nxt.buttons = $urandom;
          default: ;
        endcase
        if ($urandom_range(0, 2) == 0) nxt.trigger_left  = pick_raw16();
        if ($urandom_range(0, 2) == 0) nxt.trigger_right = pick_raw16();
        if ($urandom_range(0, 2) == 0) nxt.left_x        = pick_raw16();
        if ($urandom_range(0, 2) == 0) nxt.left_y        = pick_raw16();
        if ($urandom_range(0, 2) == 0) nxt.right_x       = pick_raw16();
        if ($urandom_range(0, 2) == 0) nxt.right_y       = pick_raw16();
        cur = nxt;
        stim_q.push_back(cur);
      end else if (pick < 78) begin
        cur = state_rpt(8'($urandom_range(18, 255)), $urandom, pick_raw16(), pick_raw16(),
                        pick_raw16(), pick_raw16(), pick_raw16(), pick_raw16());
        stim_q.push_back(cur);
      end else if (pick < 85) begin
        stim_q.push_back(state_rpt(8'($urandom_range(0, 17)), $urandom, pick_raw16(),
                                   pick_raw16(), pick_raw16(), pick_raw16(), pick_raw16(),
                                   pick_raw16()));
      end else if (pick < 93) begin
        stim_q.push_back(status_rpt(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1)
                                                                    : $urandom_range(2, 255)),
                                    STATUS_CONNECT));
      end else begin
        stim_q.push_back(status_rpt(8'($urandom_range(0, 255)), 8'($urandom)));
      end
    end

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every item handed over, every event seen, then a quiet stretch
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // hang detection: too long without any item crossing either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: offers the next report on the falling edge, with a random gap per item
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (in_took) begin
      // flip now and then between gapped traffic and back-to-back bursts
      if ($urandom_range(0, 24) == 0) in_burst = !in_burst;
      in_gap = in_burst ? 0 : $urandom_range(0, 19);
    end
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        in_item  <= stim_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall after each event, plus long hold-offs to back the block up
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 24) == 0) out_burst = !out_burst;
      out_gap = out_burst ? 0 : $urandom_range(0, 19);
      if (got_count == 30 || got_count == 1500) squeeze = SQUEEZE_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (squeeze > 0) begin
      squeeze--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted report, checks each accepted event in order
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    in_took  <= !rst && in_valid && in_ready;
    out_took <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) predict_events(in_item);
      if (out_valid && out_ready) begin
        got_count <= got_count + 1;
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event, expected none, got kind %0d code %0d value %0d last %0d",
                   $time, out_item.event_kind, out_item.event_code,
                   $signed(out_item.event_value), out_item.last_event);
          mismatches++;
        end else begin
          head_event = events_due.pop_front();
          check_field("event_kind", 32'(head_event.event_kind), 32'(out_item.event_kind));
          check_field("event_code", 32'(head_event.event_code), 32'(out_item.event_code));
          check_field("event_value", 32'($signed(head_event.event_value)),
                      32'($signed(out_item.event_value)));
          check_field("last_event", 32'(head_event.last_event), 32'(out_item.last_event));
        end
      end
    end
  end

endmodule

### sim.f
rtl/gpde_pkg.sv
rtl/gpde_ram.sv
rtl/gamepad_report_to_delta_events.sv
tb/sv/testbench.sv
